/* design/fptr_pkg.sv */
// Shared widths, constants, register codes and sideband type for the fisheye pixel-to-ray core.
package fptr_pkg;

	localparam int TRIG_ITERATIONS = 18;

	localparam int PIX_W   = 16;
	localparam int D_W     = 17;
	localparam int R2_W    = 34;
	localparam int RSQ_W   = R2_W + 8;
	localparam int R_W     = RSQ_W / 2;
	localparam int RPP_W   = 24;
	localparam int ALPHA_W = R_W + RPP_W;
	localparam int RED_N   = 11;
	localparam int CW      = 34;
	localparam int FOLD_W  = 36;
	localparam int RAY_W   = 18;
	localparam int PROD_W  = D_W + CW;
	localparam int NUM_W   = PROD_W + 1;
	localparam int DEN_W   = R_W + 10;
	localparam int Q_W     = 18;
	localparam int DIM_W   = 13;
	localparam int CFG_W   = 34;
	localparam int ADDR_W  = 3;

	localparam logic [ALPHA_W-1:0] TWO_PI_Q32 = 45'd26986075409;
	localparam logic signed [FOLD_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [FOLD_W-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [FOLD_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [RAY_W-1:0] ONE_Q16 = 18'sd65536;

	localparam logic [29:0] ATAN_Q30 [24] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686, 30'd33543515, 30'd16775850, 30'd8388437,
		30'd4194282, 30'd2097149, 30'd1048575, 30'd524287,
		30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127
	};

	typedef enum logic [ADDR_W-1:0] {
		REG_CENTRE_X      = 3'd0,
		REG_CENTRE_Y      = 3'd1,
		REG_RAD_PER_PIXEL = 3'd2,
		REG_CIRCLE_RSQ    = 3'd3,
		REG_IMAGE_WIDTH   = 3'd4,
		REG_IMAGE_HEIGHT  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [D_W-1:0]   dx;
		logic signed [D_W-1:0]   dy;
		logic [R_W-1:0]          r;
		logic signed [RAY_W-1:0] rz;
		logic                    in_view;
	} side_t;

endpackage

/* design/fptr_front.sv */
// Front end: centre offset, bounds check, squared radius and image-circle test.
module fptr_front import fptr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [PIX_W-1:0]  pixel_x,
	input  logic [PIX_W-1:0]  pixel_y,
	input  logic [PIX_W-1:0]  centre_x,
	input  logic [PIX_W-1:0]  centre_y,
	input  logic [R2_W-1:0]   circle_rsq,
	input  logic [DIM_W-1:0]  image_width,
	input  logic [DIM_W-1:0]  image_height,
	output logic              out_valid,
	output side_t             out_side,
	output logic [R2_W-1:0]   r2
);

	logic signed [D_W-1:0]    dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic                     inb_s1, inb_s2;
	logic signed [2*D_W-1:0]  sqx_s2, sqy_s2;
	logic [R2_W-1:0]          r2_s3;
	logic                     view_s3;
	logic                     v_s1, v_s2, v_s3;
	logic [R2_W-1:0]          r2_sum;

	assign r2_sum = R2_W'(sqx_s2) + R2_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= signed'({1'b0, pixel_x}) - signed'({1'b0, centre_x});
			dy_s1  <= signed'({1'b0, pixel_y}) - signed'({1'b0, centre_y});
			inb_s1 <= ({1'b0, pixel_x} < {image_width, 4'b0}) &&
			          ({1'b0, pixel_y} < {image_height, 4'b0});
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			inb_s2 <= inb_s1;
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			r2_s3  <= r2_sum;
			view_s3 <= inb_s2 && (r2_sum <= circle_rsq);
		end
	end

	always_comb begin
		out_side         = '0;
		out_side.dx      = dx_s3;
		out_side.dy      = dy_s3;
		out_side.in_view = view_s3;
	end

	assign out_valid = v_s3;
	assign r2        = r2_s3;

endmodule

/* design/fptr_sqrt.sv */
// Pipelined integer square root of the scaled squared radius, one root bit per stage.
module fptr_sqrt import fptr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  side_t           in_side,
	input  logic [R2_W-1:0] r2,
	output logic            out_valid,
	output side_t           out_side
);

	localparam int REM_W = RSQ_W + 2;

	logic [REM_W-1:0] rem_s  [R_W+1];
	logic [R_W-1:0]   root_s [R_W+1];
	logic             v_s    [R_W+1];
	side_t            side_s [R_W+1];

	assign rem_s[0]  = REM_W'({r2, 8'b0});
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < R_W; j++) begin : g_stage
		localparam int B = R_W - 1 - j;
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = (REM_W'(root_s[j]) << (B + 1)) | (REM_W'(1) << (2 * B));
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= take ? (root_s[j] | (R_W'(1) << B)) : root_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	always_comb begin
		out_side   = side_s[R_W];
		out_side.r = root_s[R_W];
	end

	assign out_valid = v_s[R_W];

endmodule

/* design/fptr_angle.sv */
// View angle: radius times scale, reduction modulo two pi, fold into the right half plane.
module fptr_angle import fptr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  side_t             in_side,
	input  logic [RPP_W-1:0]  rad_per_pixel,
	output logic              out_valid,
	output side_t             out_side,
	output logic signed [CW-1:0] theta,
	output logic              flip
);

	logic [ALPHA_W-1:0] a_s    [RED_N+1];
	logic               v_s    [RED_N+1];
	side_t              side_s [RED_N+1];

	logic                    v_f_s;
	side_t                   side_f_s;
	logic signed [CW-1:0]    t_f_s;
	logic                    flip_f_s;

	logic signed [FOLD_W-1:0] t_raw, t_wrap, t_fold;
	logic                     fl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0]    <= ALPHA_W'(in_side.r * rad_per_pixel);
			side_s[0] <= in_side;
		end
	end

	// Subtract two pi shifted down by one place per stage.
	for (genvar j = 0; j < RED_N; j++) begin : g_red
		localparam int K = RED_N - 1 - j;
		logic [ALPHA_W-1:0] m;

		assign m = TWO_PI_Q32 << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[j+1]    <= (a_s[j] >= m) ? a_s[j] - m : a_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	always_comb begin
		t_raw  = signed'(FOLD_W'(a_s[RED_N] >> 2));
		t_wrap = (t_raw > PI_Q30) ? t_raw - TWO_PI_Q30 : t_raw;
		fl     = 1'b0;
		t_fold = t_wrap;
		priority if (t_wrap > HALF_PI_Q30) begin
			t_fold = t_wrap - PI_Q30;
			fl     = 1'b1;
		end else if (t_wrap < -HALF_PI_Q30) begin
			t_fold = t_wrap + PI_Q30;
			fl     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f_s <= 1'b0;
		end else if (en) begin
			v_f_s <= v_s[RED_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_f_s    <= CW'(t_fold);
			flip_f_s <= fl;
			side_f_s <= side_s[RED_N];
		end
	end

	assign out_valid = v_f_s;
	assign out_side  = side_f_s;
	assign theta     = t_f_s;
	assign flip      = flip_f_s;

endmodule

/* design/fptr_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per stage, then sign fix and cosine rounding.
module fptr_cordic import fptr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  side_t                in_side,
	input  logic signed [CW-1:0] theta,
	input  logic                 flip,
	output logic                 out_valid,
	output side_t                out_side,
	output logic signed [CW-1:0] sin_q30
);

	localparam int N = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [CW-1:0] t_s [N+1];
	logic                 fl_s [N+1];
	logic                 v_s [N+1];
	side_t                side_s [N+1];

	logic                 v_o_s;
	side_t                side_o_s;
	logic signed [CW-1:0] sin_o_s;

	logic signed [CW-1:0] cx, cy, zr;
	logic signed [RAY_W-1:0] rz;
	side_t                side_c;

	assign x_s[0]    = CORDIC_GAIN_Q30;
	assign y_s[0]    = '0;
	assign t_s[0]    = theta;
	assign fl_s[0]   = flip;
	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [CW-1:0] at;
		logic                 pos;

		assign at  = signed'(CW'(ATAN_Q30[i]));
		assign pos = t_s[i] >= 0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= pos ? x_s[i] - (y_s[i] >>> i) : x_s[i] + (y_s[i] >>> i);
				y_s[i+1]    <= pos ? y_s[i] + (x_s[i] >>> i) : y_s[i] - (x_s[i] >>> i);
				t_s[i+1]    <= pos ? t_s[i] - at : t_s[i] + at;
				fl_s[i+1]   <= fl_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_comb begin
		cx = fl_s[N] ? -x_s[N] : x_s[N];
		cy = fl_s[N] ? -y_s[N] : y_s[N];
		zr = (cx + CW'(8192)) >>> 14;
		if (zr > CW'(ONE_Q16)) begin
			rz = ONE_Q16;
		end else if (zr < -CW'(ONE_Q16)) begin
			rz = -ONE_Q16;
		end else begin
			rz = RAY_W'(zr);
		end
		side_c    = side_s[N];
		side_c.rz = rz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_s <= 1'b0;
		end else if (en) begin
			v_o_s <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o_s  <= cy;
			side_o_s <= side_c;
		end
	end

	assign out_valid = v_o_s;
	assign out_side  = side_o_s;
	assign sin_q30   = sin_o_s;

endmodule

/* design/fptr_scale.sv */
// Lateral components: offset times sine, divided by the radius with rounding, one quotient bit per stage.
module fptr_scale import fptr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  side_t                   in_side,
	input  logic signed [CW-1:0]    sin_q30,
	output logic                    out_valid,
	output logic signed [RAY_W-1:0] ray_x,
	output logic signed [RAY_W-1:0] ray_y,
	output logic signed [RAY_W-1:0] ray_z,
	output logic                    in_view
);

	logic                     v_p1, v_p2;
	side_t                    side_p1, side_p2;
	logic signed [PROD_W-1:0] prod_p1 [2];
	logic                     neg_p2  [2];
	logic                     ovf_p2  [2];
	logic [NUM_W-1:0]         num_p2  [2];
	logic [NUM_W-1:0]         den_p2;

	logic [NUM_W-1:0] rem_s  [2][Q_W+1];
	logic [Q_W-1:0]   q_s    [2][Q_W+1];
	logic             neg_s  [2][Q_W+1];
	logic             ovf_s  [2][Q_W+1];
	logic [NUM_W-1:0] den_s  [Q_W+1];
	logic             v_s    [Q_W+1];
	side_t            side_s [Q_W+1];

	logic                    v_o_s;
	logic signed [RAY_W-1:0] rx_o_s, ry_o_s, rz_o_s;
	logic                    view_o_s;
	logic signed [RAY_W-1:0] res [2];

	logic [DEN_W-1:0] den_c;
	assign den_c = {side_p1.r, 10'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p1 <= in_valid;
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p1[0] <= PROD_W'(in_side.dx) * PROD_W'(sin_q30);
			prod_p1[1] <= PROD_W'(in_side.dy) * PROD_W'(sin_q30);
			side_p1    <= in_side;
			side_p2    <= side_p1;
			den_p2     <= NUM_W'(den_c);
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [PROD_W-1:0] mag;
		logic [NUM_W-1:0]  num;

		assign mag = prod_p1[l][PROD_W-1] ? PROD_W'(-prod_p1[l]) : PROD_W'(prod_p1[l]);
		assign num = NUM_W'(mag) + NUM_W'(den_c >> 1);

		always_ff @(posedge clk) begin
			if (en) begin
				neg_p2[l] <= prod_p1[l][PROD_W-1];
				num_p2[l] <= num;
				ovf_p2[l] <= num >= (NUM_W'(den_c) << Q_W);
			end
		end

		assign rem_s[l][0] = num_p2[l];
		assign q_s[l][0]   = '0;
		assign neg_s[l][0] = neg_p2[l];
		assign ovf_s[l][0] = ovf_p2[l];

		for (genvar j = 0; j < Q_W; j++) begin : g_div
			localparam int K = Q_W - 1 - j;
			logic [NUM_W-1:0] d;
			logic             take;

			assign d    = den_s[j] << K;
			assign take = rem_s[l][j] >= d;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][j+1] <= take ? rem_s[l][j] - d : rem_s[l][j];
					q_s[l][j+1]   <= take ? (q_s[l][j] | (Q_W'(1) << K)) : q_s[l][j];
					neg_s[l][j+1] <= neg_s[l][j];
					ovf_s[l][j+1] <= ovf_s[l][j];
				end
			end
		end

		// Saturate to one, force zero on the optical axis, reapply the sign.
		always_comb begin
			logic [Q_W:0] qv;
			qv = ovf_s[l][Q_W] ? (Q_W + 1)'(ONE_Q16) : {1'b0, q_s[l][Q_W]};
			if (qv > (Q_W + 1)'(ONE_Q16)) begin
				qv = (Q_W + 1)'(ONE_Q16);
			end
			if (side_s[Q_W].r == '0) begin
				res[l] = '0;
			end else if (neg_s[l][Q_W]) begin
				res[l] = -signed'(RAY_W'(qv));
			end else begin
				res[l] = signed'(RAY_W'(qv));
			end
		end
	end

	assign den_s[0]  = den_p2;
	assign v_s[0]    = v_p2;
	assign side_s[0] = side_p2;

	for (genvar j = 0; j < Q_W; j++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_s <= 1'b0;
		end else if (en) begin
			v_o_s <= v_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_o_s   <= res[0];
			ry_o_s   <= res[1];
			rz_o_s   <= side_s[Q_W].rz;
			view_o_s <= side_s[Q_W].in_view;
		end
	end

	assign out_valid = v_o_s;
	assign ray_x     = rx_o_s;
	assign ray_y     = ry_o_s;
	assign ray_z     = rz_o_s;
	assign in_view   = view_o_s;

endmodule

/* design/fisheye_pixel_to_ray_core.sv */
// Top level of the equidistant fisheye pixel-to-ray core: config registers and pipeline.
// An accepted request flows through the front, root, angle, CORDIC and divide
// stages to its result. Throughput: one request per cycle while the output is not
// stalled; the whole pipeline advances together, so a stalled output holds every stage in place.
// Reset: arst_n clears all valid bits and loads the register defaults
// (centre 320,240 px, 640x480 image); payload registers are not reset.
module fisheye_pixel_to_ray_core import fptr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel requests in.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // pixel_x [15:0], pixel_y [31:16]
	// Rays out.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,   // ray_x [17:0], ray_y [35:18], ray_z [53:36],
	                                     // in_view [54], zero [55]
	// Configuration writes.
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	logic [PIX_W-1:0] centre_x_q, centre_y_q;
	logic [RPP_W-1:0] rpp_q;
	logic [R2_W-1:0]  crsq_q;
	logic [DIM_W-1:0] width_q, height_q;

	// Register writes; unknown indexes fall through and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= 16'd5120;
			centre_y_q <= 16'd3840;
			rpp_q      <= 24'd83886;
			crsq_q     <= 34'd14745600;
			width_q    <= 13'd640;
			height_q   <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CENTRE_X:      centre_x_q <= cfg_wdata[PIX_W-1:0];
				REG_CENTRE_Y:      centre_y_q <= cfg_wdata[PIX_W-1:0];
				REG_RAD_PER_PIXEL: rpp_q      <= cfg_wdata[RPP_W-1:0];
				REG_CIRCLE_RSQ:    crsq_q     <= cfg_wdata[R2_W-1:0];
				REG_IMAGE_WIDTH:   width_q    <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  height_q   <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance every stage unless a finished ray waits in the output register.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic            v_fr, v_sq, v_an, v_co;
	side_t           side_fr, side_sq, side_an, side_co;
	logic [R2_W-1:0] r2;
	logic signed [CW-1:0] theta, sin_q30;
	logic            flip;
	logic signed [RAY_W-1:0] ray_x, ray_y, ray_z;
	logic            in_view;

	fptr_front u_front (
		.clk, .arst_n, .en,
		.in_valid     (s_tvalid),
		.pixel_x      (s_tdata[15:0]),
		.pixel_y      (s_tdata[31:16]),
		.centre_x     (centre_x_q),
		.centre_y     (centre_y_q),
		.circle_rsq   (crsq_q),
		.image_width  (width_q),
		.image_height (height_q),
		.out_valid    (v_fr),
		.out_side     (side_fr),
		.r2           (r2)
	);

	fptr_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid  (v_fr),
		.in_side   (side_fr),
		.r2        (r2),
		.out_valid (v_sq),
		.out_side  (side_sq)
	);

	fptr_angle u_angle (
		.clk, .arst_n, .en,
		.in_valid      (v_sq),
		.in_side       (side_sq),
		.rad_per_pixel (rpp_q),
		.out_valid     (v_an),
		.out_side      (side_an),
		.theta         (theta),
		.flip          (flip)
	);

	fptr_cordic u_cordic (
		.clk, .arst_n, .en,
		.in_valid  (v_an),
		.in_side   (side_an),
		.theta     (theta),
		.flip      (flip),
		.out_valid (v_co),
		.out_side  (side_co),
		.sin_q30   (sin_q30)
	);

	// Last stage of the divider is the output register.
	fptr_scale u_scale (
		.clk, .arst_n, .en,
		.in_valid  (v_co),
		.in_side   (side_co),
		.sin_q30   (sin_q30),
		.out_valid (m_tvalid),
		.ray_x     (ray_x),
		.ray_y     (ray_y),
		.ray_z     (ray_z),
		.in_view   (in_view)
	);

	assign m_tdata = {1'b0, in_view, ray_z, ray_y, ray_x};

endmodule

/* test/tb_fisheye_pixel_to_ray_core.sv */
// Testbench for the fisheye pixel-to-ray core: directed and randomized pixel streams checked against a predictor.
`timescale 1ns / 1ps

module tb_fisheye_pixel_to_ray_core;
	import fptr_pkg::*;

	localparam int LATENCY = 77;

	typedef struct {
		logic signed [RAY_W-1:0] rx;
		logic signed [RAY_W-1:0] ry;
		logic signed [RAY_W-1:0] rz;
		logic                    view;
	} ray_t;

	// Predictor state: a private copy of the register file.
	logic [15:0] p_cx, p_cy;
	logic [23:0] p_rpp;
	logic [33:0] p_rsq;
	logic [12:0] p_w, p_h;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > 65536)
			return 65536;
		if (v < -65536)
			return -65536;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint radius_scale(longint d, longint s, longint unsigned r);
		longint num;
		longint unsigned mag, den;
		longint q;
		num = d * s;
		mag = (num < 0) ? -num : num;
		den = r << 10;
		q = (mag + (den >> 1)) / den;
		return clamp_one((num < 0) ? -q : q);
	endfunction

	// Map one pixel to its expected ray.
	function automatic ray_t pixel_ray(logic [15:0] px, logic [15:0] py);
		ray_t o;
		longint dx, dy, t, cx, cy, nx;
		longint unsigned r2, r, alpha;
		longint atan_tab [24];
		bit flip;
		for (int i = 0; i < 24; i++)
			atan_tab[i] = ATAN_Q30[i];
		dx = longint'(px) - longint'(p_cx);
		dy = longint'(py) - longint'(p_cy);
		r2 = dx * dx + dy * dy;
		r = int_sqrt(r2 << 8);
		alpha = (r * p_rpp) % 64'd26986075409;
		t = alpha >> 2;
		flip = 0;
		if (t > 64'sd3373259426)
			t -= 64'sd6746518852;
		if (t > 64'sd1686629713) begin
			t -= 64'sd3373259426;
			flip = 1;
		end else if (t < -64'sd1686629713) begin
			t += 64'sd3373259426;
			flip = 1;
		end
		cx = 652032874;
		cy = 0;
		for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
			if (t >= 0) begin
				nx = cx - floor_shift(cy, i);
				cy = cy + floor_shift(cx, i);
				t -= atan_tab[i];
			end else begin
				nx = cx + floor_shift(cy, i);
				cy = cy - floor_shift(cx, i);
				t += atan_tab[i];
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		o.rz = clamp_one(floor_shift(cx + 8192, 14));
		if (r == 0) begin
			o.rx = 0;
			o.ry = 0;
		end else begin
			o.rx = radius_scale(dx, cy, r);
			o.ry = radius_scale(dy, cy, r);
		end
		o.view = (r2 <= p_rsq) && (px < ({19'd0, p_w} << 4)) && (py < ({19'd0, p_h} << 4));
		return o;
	endfunction

	class ray_board;
		ray_t pending[$];
		int   errors;

		function void note_pixel(logic [31:0] d);
			pending.push_back(pixel_ray(d[15:0], d[31:16]));
		endfunction

		function void check_ray(logic [55:0] d);
			ray_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected ray %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[17:0] !== e.rx) begin
				$display("%0t: ray_x expected %0d actual %0d", $time, e.rx, $signed(d[17:0]));
				errors++;
			end
			if (d[35:18] !== e.ry) begin
				$display("%0t: ray_y expected %0d actual %0d", $time, e.ry, $signed(d[35:18]));
				errors++;
			end
			if (d[53:36] !== e.rz) begin
				$display("%0t: ray_z expected %0d actual %0d", $time, e.rz, $signed(d[53:36]));
				errors++;
			end
			if (d[54] !== e.view) begin
				$display("%0t: in_view expected %0b actual %0b", $time, e.view, d[54]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [31:0] s_tdata;
	logic [55:0] m_tdata;
	logic cfg_we;
	logic [ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	ray_board board = new();
	bit calm;          // no idling in the last part of the run
	int hold_off;      // long receiver stall request, in cycles

	fisheye_pixel_to_ray_core dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off when asked.
	initial begin
		int idle;
		m_tready = 0;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_ray(m_tdata);
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 0;
			end else if (idle > 0) begin
				idle--;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				idle = $urandom_range(1, 8) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Offer one pixel request and hold it until taken.
	task automatic send_pixel(logic [15:0] px, logic [15:0] py);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		board.note_pixel({py, px});
	endtask

	// Lower valid and wait until every ray is back, then let the pipe drain.
	task automatic drain;
		s_tvalid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Register write, applied to the predictor too; idle block only.
	task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_CENTRE_X:      p_cx = val[15:0];
			REG_CENTRE_Y:      p_cy = val[15:0];
			REG_RAD_PER_PIXEL: p_rpp = val[23:0];
			REG_CIRCLE_RSQ:    p_rsq = val[33:0];
			REG_IMAGE_WIDTH:   p_w = val[12:0];
			REG_IMAGE_HEIGHT:  p_h = val[12:0];
			default: ;
		endcase
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: send_pixel(16'($urandom), 16'($urandom));
				1: send_pixel(16'(p_cx + $urandom_range(0, 64) - 32),
					16'(p_cy + $urandom_range(0, 64) - 32));
				default: send_pixel(16'($urandom_range(0, p_w * 16 + 32)),
					16'($urandom_range(0, p_h * 16 + 32)));
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_we = 0;
		cfg_addr = REG_CENTRE_X;
		cfg_wdata = 0;
		calm = 0;
		hold_off = 0;
		p_cx = 5120; p_cy = 3840; p_rpp = 83886; p_rsq = 14745600; p_w = 640; p_h = 480;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: centre, corners, bound edges, field extremes.
		send_pixel(p_cx, p_cy);
		send_pixel(0, 0);
		send_pixel(16'hFFFF, 16'hFFFF);
		send_pixel(16'hFFFF, 0);
		send_pixel(0, 16'hFFFF);
		send_pixel(16'(640 * 16 - 1), 16'(480 * 16 - 1));
		send_pixel(16'(640 * 16), 100);
		send_pixel(100, 16'(480 * 16));
		send_pixel(16'(p_cx + 1), p_cy);
		send_pixel(p_cx, 16'(p_cy - 1));
		send_pixel(16'hAAAA, 16'h5555);
		send_pixel(16'h5555, 16'hAAAA);
		drain();

		// Extremes: zero dims, max rate, max circle, centre at a corner.
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		write_reg(REG_RAD_PER_PIXEL, 24'hFFFFFF);
		write_reg(REG_CIRCLE_RSQ, 34'h3FFFFFFFF);
		write_reg(REG_CENTRE_X, 16'hFFFF);
		write_reg(REG_CENTRE_Y, 0);
		send_pixel(0, 16'hFFFF);
		send_pixel(16'hFFFF, 0);
		send_pixel(1234, 4321);
		send_pixel(16'hFFFF, 16'hFFFF);
		drain();
		write_reg(REG_IMAGE_WIDTH, 4096);
		write_reg(REG_IMAGE_HEIGHT, 0);
		write_reg(REG_RAD_PER_PIXEL, 0);
		write_reg(REG_CIRCLE_RSQ, 0);
		write_reg(REG_CENTRE_X, 0);
		write_reg(REG_CENTRE_Y, 16'hFFFF);
		send_pixel(0, 16'hFFFF);
		send_pixel(0, 0);
		send_pixel(16'hFFFF, 16'hFFFF);
		drain();

		// Long receiver hold-off while the sender keeps pushing.
		write_reg(REG_CENTRE_X, 5120);
		write_reg(REG_CENTRE_Y, 3840);
		write_reg(REG_RAD_PER_PIXEL, 83886);
		write_reg(REG_CIRCLE_RSQ, 14745600);
		write_reg(REG_IMAGE_WIDTH, 640);
		write_reg(REG_IMAGE_HEIGHT, 480);
		hold_off = 300;
		random_phase(200);
		drain();

		// Random settings phases.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_CENTRE_X, $urandom);
			write_reg(REG_CENTRE_Y, $urandom);
			write_reg(REG_RAD_PER_PIXEL, (ph % 2) ? $urandom : $urandom_range(0, 400000));
			write_reg(REG_CIRCLE_RSQ, CFG_W'({$urandom, $urandom}));
			write_reg(REG_IMAGE_WIDTH, $urandom);
			write_reg(REG_IMAGE_HEIGHT, $urandom);
			random_phase(200);
			drain();
		end

		calm = 1;
		random_phase(200);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
